// ===== hdl/bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types and constants of the button gesture recognizer: request and
// response payloads, configuration set, register indexes and trigger modes.
// ----------------------------------------------------------------------------
package bgr_pkg;

   localparam int TIME_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_TICKS    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DTAP_WINDOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DTAP_PEER    = 3'd4;

   localparam logic [2:0] MODE_PRESS      = 3'd0;
   localparam logic [2:0] MODE_RELEASE    = 3'd1;
   localparam logic [2:0] MODE_HOLD       = 3'd2;
   localparam logic [2:0] MODE_TAP        = 3'd3;
   localparam logic [2:0] MODE_DOUBLE_TAP = 3'd4;
   localparam logic [2:0] MODE_CONTINUOUS = 3'd5;
   localparam logic [2:0] MODE_TOGGLE     = 3'd6;

   localparam logic [2:0]  RESET_TRIGGER_MODE = MODE_PRESS;
   localparam logic [15:0] RESET_HOLD_TICKS   = 16'd500;
   localparam logic [15:0] RESET_TAP_TICKS    = 16'd250;
   localparam logic [15:0] RESET_DTAP_WINDOW  = 16'd300;

   typedef struct packed {
      logic        active;
      logic [31:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic held;
      logic fired;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  trigger_mode;
      logic [15:0] hold_ticks;
      logic [15:0] tap_ticks;
      logic [15:0] double_tap_window_ticks;
      logic        has_double_tap_peer;
   } cfg_type;

endpackage

// ===== hdl/bgr_csr.sv =====
// ----------------------------------------------------------------------------
// bgr_csr
// Configuration registers of the recognizer, written through a plain write
// port; writes to indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module bgr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [bgr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bgr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output bgr_pkg::cfg_type                     cfg
);
   import bgr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TRIGGER_MODE: cfg_in.trigger_mode = csr_wdata[2:0];
            CSR_HOLD_TICKS:   cfg_in.hold_ticks = csr_wdata;
            CSR_TAP_TICKS:    cfg_in.tap_ticks = csr_wdata;
            CSR_DTAP_WINDOW:  cfg_in.double_tap_window_ticks = csr_wdata;
            CSR_DTAP_PEER:    cfg_in.has_double_tap_peer = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_mode            <= RESET_TRIGGER_MODE;
         cfg_ff.hold_ticks              <= RESET_HOLD_TICKS;
         cfg_ff.tap_ticks               <= RESET_TAP_TICKS;
         cfg_ff.double_tap_window_ticks <= RESET_DTAP_WINDOW;
         cfg_ff.has_double_tap_peer     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/bgr_core.sv =====
// ----------------------------------------------------------------------------
// bgr_core
// Gesture state and the single-pass evaluation of one sample: edge detection,
// press timing and the per-mode held and fired decision.
// ----------------------------------------------------------------------------
module bgr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  bgr_pkg::req_type  sample,
   input  bgr_pkg::cfg_type  cfg,
   output bgr_pkg::rsp_type  result
);
   import bgr_pkg::*;

   logic                 prev_down_ff, prev_down_in;
   logic [TIME_BITS-1:0] down_time_ff, down_time_in;
   logic                 hold_done_ff, hold_done_in;
   logic                 tap_pending_ff, tap_pending_in;
   logic [TIME_BITS-1:0] pending_time_ff, pending_time_in;
   logic                 swallow_release_ff, swallow_release_in;
   logic [TIME_BITS-1:0] last_tap_time_ff, last_tap_time_in;
   logic                 last_tap_valid_ff, last_tap_valid_in;
   logic                 toggle_state_ff, toggle_state_in;

   logic                 down;
   logic [TIME_BITS-1:0] now;
   logic                 rising;
   logic                 falling;
   logic [TIME_BITS-1:0] dur;
   logic [TIME_BITS-1:0] since_pending;
   logic [TIME_BITS-1:0] since_last_tap;
   logic                 short_press;
   logic                 held;
   logic                 fired;

   assign down    = sample.active;
   assign now     = TIME_BITS'(sample.now_ticks);
   assign rising  = down & ~prev_down_ff;
   assign falling = ~down & prev_down_ff;
   assign dur     = rising ? '0 : now - down_time_ff;
   assign since_last_tap = now - last_tap_time_ff;
   assign short_press = dur < TIME_BITS'(cfg.tap_ticks);

   always_comb begin
      down_time_in       = rising ? now : down_time_ff;
      hold_done_in       = rising ? 1'b0 : hold_done_ff;
      tap_pending_in     = tap_pending_ff;
      pending_time_in    = pending_time_ff;
      swallow_release_in = swallow_release_ff;
      last_tap_time_in   = last_tap_time_ff;
      last_tap_valid_in  = last_tap_valid_ff;
      toggle_state_in    = toggle_state_ff;
      since_pending      = '0;
      held               = 1'b0;
      fired              = 1'b0;

      case (cfg.trigger_mode)
         MODE_PRESS, MODE_CONTINUOUS: begin
            held  = down;
            fired = rising;
         end
         MODE_RELEASE: begin
            held  = falling;
            fired = falling;
         end
         MODE_HOLD: begin
            if (down && dur >= TIME_BITS'(cfg.hold_ticks)) begin
               held = 1'b1;
               if (!hold_done_in) begin
                  fired        = 1'b1;
                  hold_done_in = 1'b1;
               end
            end
         end
         MODE_TAP: begin
            if (rising && tap_pending_ff) begin
               tap_pending_in     = 1'b0;
               swallow_release_in = 1'b1;
            end
            if (falling) begin
               if (swallow_release_in) begin
                  swallow_release_in = 1'b0;
               end else if (short_press) begin
                  if (cfg.has_double_tap_peer) begin
                     tap_pending_in  = 1'b1;
                     pending_time_in = now;
                  end else begin
                     fired = 1'b1;
                  end
               end
            end
            since_pending = now - pending_time_in;
            if (tap_pending_in && !down &&
                since_pending > TIME_BITS'(cfg.double_tap_window_ticks)) begin
               tap_pending_in = 1'b0;
               fired          = 1'b1;
            end
            held = fired;
         end
         MODE_DOUBLE_TAP: begin
            if (rising && last_tap_valid_ff &&
                since_last_tap <= TIME_BITS'(cfg.double_tap_window_ticks)) begin
               fired              = 1'b1;
               last_tap_valid_in  = 1'b0;
               swallow_release_in = 1'b1;
            end
            if (falling) begin
               if (swallow_release_in) begin
                  swallow_release_in = 1'b0;
               end else if (short_press) begin
                  last_tap_time_in  = now;
                  last_tap_valid_in = 1'b1;
               end
            end
            held = fired;
         end
         MODE_TOGGLE: begin
            if (rising) begin
               toggle_state_in = ~toggle_state_ff;
               fired           = toggle_state_in;
            end
            held = toggle_state_in;
         end
         default: begin
            held  = 1'b0;
            fired = 1'b0;
         end
      endcase
      prev_down_in = down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_down_ff       <= 1'b0;
         down_time_ff       <= '0;
         hold_done_ff       <= 1'b0;
         tap_pending_ff     <= 1'b0;
         pending_time_ff    <= '0;
         swallow_release_ff <= 1'b0;
         last_tap_time_ff   <= '0;
         last_tap_valid_ff  <= 1'b0;
         toggle_state_ff    <= 1'b0;
      end else if (step) begin
         prev_down_ff       <= prev_down_in;
         down_time_ff       <= down_time_in;
         hold_done_ff       <= hold_done_in;
         tap_pending_ff     <= tap_pending_in;
         pending_time_ff    <= pending_time_in;
         swallow_release_ff <= swallow_release_in;
         last_tap_time_ff   <= last_tap_time_in;
         last_tap_valid_ff  <= last_tap_valid_in;
         toggle_state_ff    <= toggle_state_in;
      end
   end

   assign result.held  = held;
   assign result.fired = fired;

endmodule

// ===== hdl/button_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// button_gesture_recognizer
// Tap, hold, double-tap and toggle recognizer for one button binding.
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_ready  req_data  (active, now_ticks)
//   rsp_      out   rsp_valid/rsp_ready  rsp_data  (held, fired)
//   csr_      in    csr_write            csr_index, csr_wdata
//
// A request is registered on entry, evaluated and written to the response
// register when that register is free: one request per cycle while rsp_ready is high.
// The input register refills while a response waits, so a stalled response
// holds at most one further request. Reset is synchronous and restores the
// configuration defaults and clears all gesture state.
// ----------------------------------------------------------------------------
module button_gesture_recognizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bgr_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bgr_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [bgr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bgr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bgr_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_free;
   logic    step;

   bgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free  = ~out_valid_ff | rsp_ready;
   assign step      = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;

   assign in_valid_in  = (req_valid & req_ready) | (in_valid_ff & ~out_free);
   assign out_valid_in = step | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== tb/sv/gesture_checker.sv =====
// ----------------------------------------------------------------------------
// gesture_checker
// Watches the request, response and register ports of the button gesture
// recognizer. It keeps its own copy of the configuration and gesture state,
// predicts held and fired for every accepted request, and compares each
// accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gesture_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  bgr_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  bgr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [bgr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bgr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 error_count,
   output int                                 awaiting,
   output int                                 checked,
   output int                                 pulses
);
   import bgr_pkg::*;

   localparam int RING_DEPTH = 64;

   cfg_type     cfg;
   logic        was_down;
   logic [31:0] press_start;
   logic        hold_reported;
   logic        tap_deferred;
   logic [31:0] deferred_at;
   logic        eat_release;
   logic [31:0] tap_at;
   logic        tap_seen;
   logic        toggle_on;
   rsp_type     outcome_ring[0:RING_DEPTH-1];
   logic [5:0]  ring_wr;
   logic [5:0]  ring_rd;
   int          ring_count;

   function automatic rsp_type predict_gesture(input req_type sample);
      rsp_type     outcome;
      logic        down;
      logic        rising;
      logic        falling;
      logic [31:0] pressed_for;
      logic [31:0] since_tap;
      outcome = '0;
      down = sample.active;
      rising = down && !was_down;
      falling = !down && was_down;
      if (rising) begin
         press_start = sample.now_ticks;
         hold_reported = 1'b0;
      end
      pressed_for = sample.now_ticks - press_start;
      case (cfg.trigger_mode)
         MODE_PRESS, MODE_CONTINUOUS: begin
            outcome.held = down;
            outcome.fired = rising;
         end
         MODE_RELEASE: begin
            outcome.fired = falling;
            outcome.held = falling;
         end
         MODE_HOLD: begin
            if (down && pressed_for >= {16'd0, cfg.hold_ticks}) begin
               outcome.held = 1'b1;
               if (!hold_reported) begin
                  outcome.fired = 1'b1;
                  hold_reported = 1'b1;
               end
            end
         end
         MODE_TAP: begin
            if (rising && tap_deferred) begin
               tap_deferred = 1'b0;
               eat_release = 1'b1;
            end
            if (falling) begin
               if (eat_release) begin
                  eat_release = 1'b0;
               end else if (pressed_for < {16'd0, cfg.tap_ticks}) begin
                  if (cfg.has_double_tap_peer) begin
                     tap_deferred = 1'b1;
                     deferred_at = sample.now_ticks;
                  end else begin
                     outcome.fired = 1'b1;
                  end
               end
            end
            since_tap = sample.now_ticks - deferred_at;
            if (tap_deferred && !down && since_tap > {16'd0, cfg.double_tap_window_ticks}) begin
               tap_deferred = 1'b0;
               outcome.fired = 1'b1;
            end
            outcome.held = outcome.fired;
         end
         MODE_DOUBLE_TAP: begin
            since_tap = sample.now_ticks - tap_at;
            if (rising && tap_seen && since_tap <= {16'd0, cfg.double_tap_window_ticks}) begin
               outcome.fired = 1'b1;
               tap_seen = 1'b0;
               eat_release = 1'b1;
            end
            if (falling) begin
               if (eat_release) begin
                  eat_release = 1'b0;
               end else if (pressed_for < {16'd0, cfg.tap_ticks}) begin
                  tap_at = sample.now_ticks;
                  tap_seen = 1'b1;
               end
            end
            outcome.held = outcome.fired;
         end
         MODE_TOGGLE: begin
            if (rising) begin
               toggle_on = !toggle_on;
               outcome.fired = toggle_on;
            end
            outcome.held = toggle_on;
         end
         default: ;
      endcase
      was_down = down;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg = '{RESET_TRIGGER_MODE, RESET_HOLD_TICKS, RESET_TAP_TICKS,
                 RESET_DTAP_WINDOW, 1'b0};
         was_down = 1'b0;
         press_start = '0;
         hold_reported = 1'b0;
         tap_deferred = 1'b0;
         deferred_at = '0;
         eat_release = 1'b0;
         tap_at = '0;
         tap_seen = 1'b0;
         toggle_on = 1'b0;
         ring_wr = '0;
         ring_rd = '0;
         ring_count = 0;
         error_count = 0;
         checked = 0;
         pulses = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TRIGGER_MODE: cfg.trigger_mode = csr_wdata[2:0];
               CSR_HOLD_TICKS:   cfg.hold_ticks = csr_wdata;
               CSR_TAP_TICKS:    cfg.tap_ticks = csr_wdata;
               CSR_DTAP_WINDOW:  cfg.double_tap_window_ticks = csr_wdata;
               CSR_DTAP_PEER:    cfg.has_double_tap_peer = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (ring_count == RING_DEPTH) begin
               $error("prediction store full at %0d outstanding requests", ring_count);
               error_count++;
            end else begin
               outcome_ring[ring_wr] = predict_gesture(req_data);
               ring_wr = ring_wr + 6'd1;
               ring_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (ring_count == 0) begin
               $error("response with no request outstanding: held %0b fired %0b",
                      rsp_data.held, rsp_data.fired);
               error_count++;
            end else begin
               want = outcome_ring[ring_rd];
               ring_rd = ring_rd + 6'd1;
               ring_count--;
               checked++;
               if (rsp_data.fired === 1'b1) pulses++;
               if (rsp_data.held !== want.held) begin
                  $error("held: expected %0b, got %0b", want.held, rsp_data.held);
                  error_count++;
               end
               if (rsp_data.fired !== want.fired) begin
                  $error("fired: expected %0b, got %0b", want.fired, rsp_data.fired);
                  error_count++;
               end
            end
         end
      end
      awaiting = ring_count;
   end

endmodule

// ===== tb/sv/tb_button_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// tb_button_gesture_recognizer
// Drives button samples into the gesture recognizer under a sweep of trigger
// settings: a directed press and release in every mode code, then random
// taps, double taps, long presses, idle stretches and timestamp noise, with
// random stalls on both channels. The checker beside the block predicts and
// compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_button_gesture_recognizer;
   import bgr_pkg::*;

   localparam int          CLOCK_PERIOD      = 10;
   localparam longint      TIMEOUT_NS        = 64'd5_000_000;
   localparam logic [2:0]  MODE_UNUSED       = 3'd7;
   localparam int          RANDOM_PHASES     = 20;
   localparam int          PHASE_REQUESTS    = 60;
   localparam int          HOLD_OFF_PHASE    = 5;
   localparam int unsigned LONG_STALL_CYCLES = 300;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int          error_count;
   int          awaiting;
   int          checked;
   int          pulses;
   int          requests_sent = 0;
   int          settings_used = 0;
   bit          no_idle = 1'b0;
   bit          stall_order = 1'b0;
   logic [31:0] stamp = '0;

   button_gesture_recognizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gesture_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .awaiting    (awaiting),
      .checked     (checked),
      .pulses      (pulses)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cfg_type phase_settings(input int phase);
      cfg_type s;
      s.trigger_mode = 3'($urandom_range(0, 7));
      s.hold_ticks = 16'($urandom_range(0, 300));
      s.tap_ticks = 16'($urandom_range(1, 200));
      s.double_tap_window_ticks = 16'($urandom_range(1, 200));
      s.has_double_tap_peer = 1'($urandom_range(0, 1));
      case (phase)
         0:  s = '{MODE_TAP, 16'd500, 16'd40, 16'd60, 1'b1};
         1:  s = '{MODE_TAP, 16'd500, 16'd40, 16'd60, 1'b0};
         2:  s = '{MODE_DOUBLE_TAP, 16'd500, 16'd40, 16'd60, 1'b0};
         3:  s = '{MODE_HOLD, 16'd0, 16'd40, 16'd60, 1'b0};
         4:  s = '{MODE_HOLD, 16'd65535, 16'd65535, 16'd65535, 1'b1};
         5:  s = '{MODE_HOLD, 16'd120, 16'd40, 16'd60, 1'b0};
         6:  s = '{MODE_PRESS, 16'd500, 16'd250, 16'd300, 1'b0};
         7:  s = '{MODE_RELEASE, 16'd500, 16'd250, 16'd300, 1'b0};
         8:  s = '{MODE_CONTINUOUS, 16'd500, 16'd250, 16'd300, 1'b0};
         9:  s = '{MODE_TOGGLE, 16'd500, 16'd250, 16'd300, 1'b1};
         10: s = '{MODE_TAP, 16'd0, 16'd1, 16'd1, 1'b1};
         11: s = '{MODE_DOUBLE_TAP, 16'd0, 16'd65535, 16'd65535, 1'b0};
         12: s = '{MODE_TAP, 16'd65535, 16'd65535, 16'd65535, 1'b1};
         13: s = '{MODE_UNUSED, 16'd100, 16'd50, 16'd50, 1'b1};
         default: ;
      endcase
      return s;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic load_settings(input cfg_type s);
      write_csr(CSR_TRIGGER_MODE, 16'(s.trigger_mode));
      write_csr(CSR_HOLD_TICKS, s.hold_ticks);
      write_csr(CSR_TAP_TICKS, s.tap_ticks);
      write_csr(CSR_DTAP_WINDOW, s.double_tap_window_ticks);
      write_csr(CSR_DTAP_PEER, 16'(s.has_double_tap_peer));
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // drop the request and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      wait (awaiting == 0);
      @(negedge clock);
   endtask

   task automatic offer(input req_type item);
      int unsigned gap;
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic sample(input logic level, input int unsigned step);
      stamp = stamp + step;
      offer('{level, stamp});
   endtask

   task automatic press_for(input int unsigned lead, input int unsigned span);
      int unsigned parts;
      int unsigned piece;
      parts = $urandom_range(0, 2);
      piece = span / (parts + 1);
      sample(1'b1, lead);
      repeat (parts) sample(1'b1, piece);
      sample(1'b0, span - piece * parts);
   endtask

   function automatic int unsigned noise_step(input cfg_type s);
      int unsigned roll;
      roll = $urandom_range(0, 3);
      if (roll < 2) return $urandom_range(0, 100);
      if (roll == 2) return $urandom();
      return $urandom_range(0, 3 * s.double_tap_window_ticks);
   endfunction

   task automatic gesture(input cfg_type s);
      int unsigned kind;
      int unsigned lead;
      int unsigned reps;
      kind = $urandom_range(0, 9);
      lead = $urandom_range(0, 2 * s.double_tap_window_ticks + 2);
      case (kind)
         0, 1, 2: press_for(lead, $urandom_range(0, s.tap_ticks));
         3, 4: begin
            press_for(lead, $urandom_range(0, s.tap_ticks));
            press_for($urandom_range(0, s.double_tap_window_ticks + 2),
                      $urandom_range(0, s.tap_ticks));
         end
         5, 6: press_for(lead, s.hold_ticks + $urandom_range(0, 64));
         7: begin
            reps = $urandom_range(1, 3);
            repeat (reps) sample(1'b0, $urandom_range(0, 2 * s.double_tap_window_ticks + 2));
         end
         default: begin
            reps = $urandom_range(1, 4);
            repeat (reps) sample(1'($urandom_range(0, 1)), noise_step(s));
         end
      endcase
   endtask

   initial begin
      int unsigned idle_left;
      idle_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_order) begin
            stall_order = 1'b0;
            idle_left = LONG_STALL_CYCLES;
         end else if (idle_left == 0 && !no_idle && $urandom_range(0, 2) == 0) begin
            idle_left = idle_length();
         end
         if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_button_gesture_recognizer: FAIL");
      $finish;
   end

   initial begin
      cfg_type     setting;
      logic [31:0] base;
      int          phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_TRIGGER_MODE;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // press and release once in every mode code (twice for double tap), across the timestamp wrap
      for (int m = 0; m < 8; m++) begin
         drain();
         load_settings('{3'(m), 16'd0, 16'd250, 16'd300, 1'(m == MODE_TAP)});
         base = 32'hFFFF_FFFF + 32'(m) * 32'h400;
         offer('{1'b1, base});
         offer('{1'b0, base + 32'd1});
         if (3'(m) == MODE_DOUBLE_TAP) begin
            offer('{1'b1, base + 32'd50});
            offer('{1'b0, base + 32'd51});
         end
         offer('{1'b0, base + 32'd401});
         stamp = base + 32'd401;
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         setting = phase_settings(phase);
         load_settings(setting);
         no_idle = (phase % 5 == 4) || (phase == HOLD_OFF_PHASE);
         if (phase == HOLD_OFF_PHASE) stall_order = 1'b1;
         if (phase == 12) stamp = 32'hFFFF_0000;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) gesture(setting);
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Run covered %0d requests under %0d trigger settings, every mode code included,",
               requests_sent, settings_used);
      $display("with %0d responses checked, %0d fire pulses, a long response stall and wrapped time.",
               checked, pulses);
      if (error_count == 0 && awaiting == 0) begin
         $display("tb_button_gesture_recognizer: PASS");
      end else begin
         $display("tb_button_gesture_recognizer: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bgr_pkg.sv
hdl/bgr_csr.sv
hdl/bgr_core.sv
hdl/button_gesture_recognizer.sv
tb/sv/gesture_checker.sv
tb/sv/tb_button_gesture_recognizer.sv
